// ----- rtl/gcm_pkg.sv -----
// Shared types and constants for the greedy change maker.
package gcm_pkg;

    localparam int DEN_W      = 24;
    localparam int AMT_W_W    = 24;
    localparam int AMT_F_W    = 16;
    localparam int CMD_W      = 2;
    localparam int CNT_W      = 4;
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 96;
    localparam int OUT_USER_W = 2;
    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;

    localparam logic [CMD_W-1:0] CMD_LOAD_WHOLE    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_FRACTION = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REQUEST       = 2'd2;

    localparam logic KIND_ENTRY    = 1'b0;
    localparam logic KIND_STATUS   = 1'b1;
    localparam logic PART_WHOLE    = 1'b0;
    localparam logic PART_FRACTION = 1'b1;

    localparam logic REG_WHOLE_COUNT    = 1'b0;
    localparam logic REG_FRACTION_COUNT = 1'b1;

    typedef struct packed {
        logic load_en;
        logic load_part;
        logic capture;
        logic rd_part;
        logic lowest_w_en;
        logic lowest_f_en;
        logic fail_set;
        logic rem_init;
        logic rem_init_part;
        logic rem_w_save;
        logic div_start;
        logic div_take;
        logic emit_entry;
        logic emit_final;
    } gcm_cmd_t;

    typedef struct packed {
        logic early_fail;
        logic below_lowest;
        logic den_zero;
        logic div_done;
        logic quo_zero;
        logic out_free;
    } gcm_stat_t;

endpackage

// ----- rtl/gcm_divider.sv -----
// Restoring divider for 24-bit operands, one quotient bit per cycle.
module gcm_divider (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [gcm_pkg::DEN_W-1:0] dividend,
    input  logic [gcm_pkg::DEN_W-1:0] divisor,
    output logic                     done,
    output logic [gcm_pkg::DEN_W-1:0] quotient,
    output logic [gcm_pkg::DEN_W-1:0] remainder
);
    import gcm_pkg::*;

    localparam int STEP_W = $clog2(DEN_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DEN_W - 1);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [DEN_W-1:0]  acc_reg;
    logic [DEN_W-1:0]  quo_reg;
    logic [DEN_W-1:0]  dvs_reg;

    logic [DEN_W:0]    shifted;
    logic [DEN_W:0]    diff;
    logic              fits;

    assign shifted = {acc_reg, quo_reg[DEN_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign fits    = shifted >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            acc_reg <= fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
            quo_reg <= {quo_reg[DEN_W-2:0], fits};
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = acc_reg;

endmodule

// ----- rtl/gcm_datapath.sv -----
// Datapath: denomination tables, remainders, divider and result register.
module gcm_datapath #(
    parameter int MAX_DENOMINATIONS = 8,
    parameter int SLOT_W            = 3
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  gcm_pkg::gcm_cmd_t              cmd,
    input  logic [SLOT_W-1:0]              rd_addr,
    input  logic [gcm_pkg::IN_DATA_W-1:0]  in_data,
    output gcm_pkg::gcm_stat_t             stat,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [gcm_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic [gcm_pkg::OUT_USER_W-1:0] m_tuser,
    output logic                           m_tlast
);
    import gcm_pkg::*;

    logic [DEN_W-1:0]   whole_mem [MAX_DENOMINATIONS];
    logic [DEN_W-1:0]   frac_mem  [MAX_DENOMINATIONS];

    logic [2:0]         in_slot;
    logic [DEN_W-1:0]   in_den;
    logic [AMT_W_W-1:0] in_aw;
    logic [AMT_F_W-1:0] in_af;
    logic [SLOT_W+2:0]  slot_ext;
    logic [SLOT_W-1:0]  wr_addr;
    logic               wr_ok;

    logic [DEN_W-1:0]   rd_data_reg;
    logic [AMT_W_W-1:0] aw_reg;
    logic [AMT_F_W-1:0] af_reg;
    logic [DEN_W-1:0]   lowest_w_reg;
    logic [DEN_W-1:0]   lowest_f_reg;
    logic [DEN_W-1:0]   rem_reg;
    logic [DEN_W-1:0]   rem_w_reg;
    logic [DEN_W-1:0]   den_reg;
    logic               fail_reg;

    logic               div_done;
    logic [DEN_W-1:0]   div_quo;
    logic [DEN_W-1:0]   div_rem;

    logic               out_valid_reg;
    logic               out_kind_reg;
    logic               out_part_reg;
    logic [DEN_W-1:0]   out_value_reg;
    logic [DEN_W-1:0]   out_count_reg;
    logic               out_success_reg;
    logic [AMT_W_W-1:0] out_rw_reg;
    logic [AMT_F_W-1:0] out_rf_reg;
    logic               out_last_reg;

    assign in_slot  = in_data[2:0];
    assign in_den   = in_data[26:3];
    assign in_aw    = in_data[50:27];
    assign in_af    = in_data[66:51];
    assign slot_ext = {{SLOT_W{1'b0}}, in_slot};
    assign wr_addr  = slot_ext[SLOT_W-1:0];
    assign wr_ok    = int'(in_slot) < MAX_DENOMINATIONS;

    always_ff @(posedge clk)
    begin
        if (cmd.load_en && wr_ok)
        begin
            if (cmd.load_part == PART_FRACTION)
            begin
                frac_mem[wr_addr] <= in_den;
            end
            else
            begin
                whole_mem[wr_addr] <= in_den;
            end
        end
        rd_data_reg <= (cmd.rd_part == PART_FRACTION) ? frac_mem[rd_addr] : whole_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            aw_reg <= in_aw;
            af_reg <= in_af;
        end
        if (cmd.lowest_w_en)
        begin
            lowest_w_reg <= rd_data_reg;
        end
        if (cmd.lowest_f_en)
        begin
            lowest_f_reg <= rd_data_reg;
        end
        if (cmd.div_start)
        begin
            den_reg <= rd_data_reg;
        end
        if (cmd.fail_set)
        begin
            rem_w_reg <= aw_reg;
            rem_reg   <= {{(DEN_W-AMT_F_W){1'b0}}, af_reg};
        end
        else
        begin
            if (cmd.rem_w_save)
            begin
                rem_w_reg <= rem_reg;
            end
            if (cmd.rem_init)
            begin
                rem_reg <= (cmd.rem_init_part == PART_FRACTION)
                           ? {{(DEN_W-AMT_F_W){1'b0}}, af_reg} : aw_reg;
            end
            else if (cmd.div_take)
            begin
                rem_reg <= div_rem;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fail_reg <= 1'b0;
        end
        else if (cmd.capture)
        begin
            fail_reg <= 1'b0;
        end
        else if (cmd.fail_set)
        begin
            fail_reg <= 1'b1;
        end
    end

    gcm_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (rem_reg),
        .divisor   (rd_data_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_comb
    begin
        stat.early_fail   = (aw_reg < lowest_w_reg)
                            || ({{(DEN_W-AMT_F_W){1'b0}}, af_reg} < rd_data_reg);
        stat.below_lowest = rem_reg < ((cmd.rd_part == PART_FRACTION) ? lowest_f_reg
                                                                       : lowest_w_reg);
        stat.den_zero     = rd_data_reg == '0;
        stat.div_done     = div_done;
        stat.quo_zero     = div_quo == '0;
        stat.out_free     = !out_valid_reg || m_tready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_entry || cmd.emit_final)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_entry)
        begin
            out_kind_reg    <= KIND_ENTRY;
            out_part_reg    <= cmd.rd_part;
            out_value_reg   <= den_reg;
            out_count_reg   <= div_quo;
            out_success_reg <= 1'b0;
            out_rw_reg      <= '0;
            out_rf_reg      <= '0;
            out_last_reg    <= 1'b0;
        end
        else if (cmd.emit_final)
        begin
            out_kind_reg    <= KIND_STATUS;
            out_part_reg    <= PART_WHOLE;
            out_value_reg   <= '0;
            out_count_reg   <= '0;
            out_success_reg <= !fail_reg && (rem_w_reg == '0) && (rem_reg == '0);
            out_rw_reg      <= rem_w_reg;
            out_rf_reg      <= rem_reg[AMT_F_W-1:0];
            out_last_reg    <= 1'b1;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_rf_reg, out_rw_reg, out_success_reg,
                       out_count_reg, out_value_reg};
    assign m_tuser  = {out_part_reg, out_kind_reg};
    assign m_tlast  = out_last_reg;

endmodule

// ----- rtl/gcm_ctrl.sv -----
// Controller state machine that sequences loads and the greedy walk.
module gcm_ctrl #(
    parameter int SLOT_W = 3
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [gcm_pkg::CMD_W-1:0] in_command,
    input  logic [SLOT_W-1:0]         last_w,
    input  logic [SLOT_W-1:0]         last_f,
    input  gcm_pkg::gcm_stat_t        stat,
    output gcm_pkg::gcm_cmd_t         cmd,
    output logic [SLOT_W-1:0]         rd_addr
);
    import gcm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOW_W,
        S_LOW_F,
        S_EARLY,
        S_READ,
        S_CHECK,
        S_DIV,
        S_EMIT,
        S_FINAL
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [SLOT_W-1:0] idx_reg;
    logic [SLOT_W-1:0] idx_next;
    logic              part_reg;
    logic              part_next;
    logic              ready_reg;

    logic              accept;
    logic [SLOT_W-1:0] last_idx;

    assign accept   = s_tvalid && ready_reg;
    assign last_idx = (part_reg == PART_FRACTION) ? last_f : last_w;
    assign s_tready = ready_reg;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        part_next  = part_reg;
        cmd        = '0;
        cmd.rd_part = part_reg;
        rd_addr    = idx_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (in_command)
                        CMD_LOAD_WHOLE:
                        begin
                            cmd.load_en   = 1'b1;
                            cmd.load_part = PART_WHOLE;
                        end
                        CMD_LOAD_FRACTION:
                        begin
                            cmd.load_en   = 1'b1;
                            cmd.load_part = PART_FRACTION;
                        end
                        CMD_REQUEST:
                        begin
                            cmd.capture = 1'b1;
                            state_next  = S_LOW_W;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_LOW_W:
            begin
                cmd.rd_part = PART_WHOLE;
                rd_addr     = last_w;
                state_next  = S_LOW_F;
            end
            S_LOW_F:
            begin
                cmd.lowest_w_en = 1'b1;
                cmd.rd_part     = PART_FRACTION;
                rd_addr         = last_f;
                state_next      = S_EARLY;
            end
            S_EARLY:
            begin
                cmd.lowest_f_en = 1'b1;
                if (stat.early_fail)
                begin
                    cmd.fail_set = 1'b1;
                    state_next   = S_FINAL;
                end
                else
                begin
                    cmd.rem_init      = 1'b1;
                    cmd.rem_init_part = PART_WHOLE;
                    part_next         = PART_WHOLE;
                    idx_next          = '0;
                    state_next        = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_CHECK;
            end
            S_CHECK, S_EMIT:
            begin
                if (state_reg == S_CHECK && !stat.below_lowest && !stat.den_zero)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
                else if (state_reg == S_EMIT && !stat.quo_zero && !stat.out_free)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    if (state_reg == S_EMIT && !stat.quo_zero)
                    begin
                        cmd.emit_entry = 1'b1;
                    end
                    if ((state_reg == S_CHECK && stat.below_lowest) || idx_reg == last_idx)
                    begin
                        if (part_reg == PART_WHOLE)
                        begin
                            cmd.rem_w_save    = 1'b1;
                            cmd.rem_init      = 1'b1;
                            cmd.rem_init_part = PART_FRACTION;
                            part_next         = PART_FRACTION;
                            idx_next          = '0;
                            state_next        = S_READ;
                        end
                        else
                        begin
                            state_next = S_FINAL;
                        end
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_READ;
                    end
                end
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    cmd.div_take = 1'b1;
                    state_next   = S_EMIT;
                end
            end
            S_FINAL:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_final = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            part_reg  <= PART_WHOLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            part_reg  <= part_next;
            ready_reg <= state_next == S_IDLE;
        end
    end

endmodule

// ----- rtl/greedy_change_maker_core.sv -----
// Top level of the greedy change maker: register port, controller and datapath.
//
// Load commands write one denomination each. A change request first reads the
// two lowest denominations, then walks each table; every slot visited runs the
// one-bit-per-cycle 24-bit divider, except that a slot holding zero is skipped
// and the walk of a table stops early once the remainder is below its lowest
// denomination. One request is in flight at a time; the next transfer is taken
// once its status has been loaded into the output register. Counts must be
// written only while the block is idle; the block itself does not enforce this.
module greedy_change_maker_core #(
    parameter int MAX_DENOMINATIONS = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // slot[2:0], denomination[26:3], amount_whole[50:27], amount_fraction[66:51]
    input  logic [gcm_pkg::IN_DATA_W-1:0]  s_tdata,
    // command[1:0]
    input  logic [gcm_pkg::CMD_W-1:0]      s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // coin_value[23:0], coin_count[47:24], success[48], remainder_whole[72:49],
    // remainder_fraction[88:73]
    output logic [gcm_pkg::OUT_DATA_W-1:0] m_tdata,
    // kind[0], part[1]
    output logic [gcm_pkg::OUT_USER_W-1:0] m_tuser,
    output logic                           m_tlast,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [gcm_pkg::APB_AW-1:0]     paddr,
    input  logic [gcm_pkg::APB_DW-1:0]     pwdata,
    output logic [gcm_pkg::APB_DW-1:0]     prdata,
    output logic                           pready
);
    import gcm_pkg::*;

    localparam int SLOT_W = (MAX_DENOMINATIONS > 1) ? $clog2(MAX_DENOMINATIONS) : 1;

    logic [CNT_W-1:0]  whole_count_reg;
    logic [CNT_W-1:0]  fraction_count_reg;
    logic [SLOT_W-1:0] last_w;
    logic [SLOT_W-1:0] last_f;
    logic [SLOT_W-1:0] rd_addr;
    gcm_cmd_t          cmd;
    gcm_stat_t         stat;

    function automatic logic [SLOT_W-1:0] last_index(input logic [CNT_W-1:0] c);
        logic [SLOT_W-1:0] idx;
        if (c == '0)
        begin
            idx = '0;
        end
        else if (int'(c) > MAX_DENOMINATIONS)
        begin
            idx = SLOT_W'(MAX_DENOMINATIONS - 1);
        end
        else
        begin
            idx = SLOT_W'(c - 1'b1);
        end
        return idx;
    endfunction

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            whole_count_reg    <= CNT_W'(1);
            fraction_count_reg <= CNT_W'(1);
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2] == REG_WHOLE_COUNT)
            begin
                whole_count_reg <= pwdata[CNT_W-1:0];
            end
            else
            begin
                fraction_count_reg <= pwdata[CNT_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_FRACTION_COUNT)
                    ? {{(APB_DW-CNT_W){1'b0}}, fraction_count_reg}
                    : {{(APB_DW-CNT_W){1'b0}}, whole_count_reg};

    assign last_w = last_index(whole_count_reg);
    assign last_f = last_index(fraction_count_reg);

    gcm_ctrl #(
        .SLOT_W (SLOT_W)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .in_command (s_tuser),
        .last_w     (last_w),
        .last_f     (last_f),
        .stat       (stat),
        .cmd        (cmd),
        .rd_addr    (rd_addr)
    );

    gcm_datapath #(
        .MAX_DENOMINATIONS (MAX_DENOMINATIONS),
        .SLOT_W            (SLOT_W)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .rd_addr  (rd_addr),
        .in_data  (s_tdata),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ----- rtl/gcm_checker.sv -----
// Port-level checks for the greedy change maker, bound to the top level.
module gcm_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [gcm_pkg::CMD_W-1:0]      s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [gcm_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic [gcm_pkg::OUT_USER_W-1:0] m_tuser,
    input logic                           m_tlast
);
    import gcm_pkg::*;

    a_request_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser == CMD_REQUEST |=> !s_tready)
        else $error("input still ready right after a request transfer");

    a_last_marks_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (m_tuser[0] == KIND_STATUS)))
        else $error("tlast does not match the status kind");

    a_entry_fields_clear: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] == KIND_ENTRY |-> m_tdata[88:48] == '0 && m_tdata[23:0] != '0)
        else $error("entry carries status fields or a zero denomination");

    a_success_exact: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] == KIND_STATUS && m_tdata[48]
        |-> m_tdata[88:49] == '0 && m_tdata[47:0] == '0 && m_tuser[1] == PART_WHOLE)
        else $error("successful status with a remainder or coin fields");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result transfer changed");

endmodule

bind greedy_change_maker_core gcm_checker u_gcm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
